// ===== rtl/stream_find_replace_defines.svh =====
// Assertion macros shared by the stream find-and-replace RTL.
`ifndef STREAM_FIND_REPLACE_DEFINES_SVH
`define STREAM_FIND_REPLACE_DEFINES_SVH

`ifndef SYNTHESIS
`define SFR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SFR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  `SFR_ASSERT(lbl, clk, rst_n, !(expr), msg)
`else
`define SFR_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ===== rtl/sfr_pkg.sv =====
// Types and constants shared by the stream find-and-replace modules.
`default_nettype none

package sfr_pkg;

  localparam int unsigned ByteMax = 8;
  localparam logic [7:0] LINE_END = 8'h0A;

  typedef enum logic [1:0] {
    REG_PAT_LEN   = 2'd0,
    REG_PAT_BYTES = 2'd1,
    REG_REP_LEN   = 2'd2,
    REG_REP_BYTES = 2'd3
  } sfr_reg_e;

  typedef struct packed {
    logic shift;
    logic load;
  } sfr_cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/stream_find_replace.sv =====
// Top level: sequencer over a row of hold cells that rewrites a byte stream.
// A byte goes from IDLE to TRIM and CHECK, or straight to FLUSH if it is a line end or matching is off;
// REPL sends a replacement; FLUSH sends the held bytes, then the byte itself if it went there directly.
// The sequencer sends at most one result byte per cycle while the output is free; each waits in a
// pending register until the next one or the request's end moves it out. Input is taken only in IDLE.
// Reset is asynchronous: control state and configuration registers clear at once, no clearing pass.
`default_nettype none
`include "stream_find_replace_defines.svh"

module stream_find_replace import sfr_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 8,
  parameter int unsigned REPLACE_MAX = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic        m_axis_tlast    // run_last
);

  localparam int unsigned HoldDepth = (PATTERN_MAX < ByteMax) ? PATTERN_MAX : ByteMax;
  localparam int unsigned RepDepth  = (REPLACE_MAX < ByteMax) ? REPLACE_MAX : ByteMax;
  localparam int unsigned CntW      = $clog2(HoldDepth + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TRIM  = 6'b000010,
    S_CHECK = 6'b000100,
    S_REPL  = 6'b001000,
    S_FLUSH = 6'b010000,
    S_DONE  = 6'b100000
  } sfr_state_e;

  sfr_state_e state_q, state_d;

  logic [3:0]  pat_len_q, rep_len_q;
  logic [63:0] pat_bytes_q, rep_bytes_q;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [2:0]      ridx_q, ridx_d;
  logic [7:0]      b_q;
  logic            eos_q, tail_q, tail_d;
  logic [7:0]      pend_byte_q;
  logic            pend_v_q;
  logic [7:0]      out_byte_q;
  logic            out_last_q, out_v_q;

  logic [3:0] plen, rlen, cnt4;
  logic       accept, out_free, prefix;
  logic       pop, push, emit, fin, load_out;
  logic [7:0] emit_byte;

  logic [7:0]          held  [HoldDepth];
  logic [HoldDepth-1:0] match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q   <= 4'd1;
      pat_bytes_q <= '0;
      rep_len_q   <= 4'd0;
      rep_bytes_q <= '0;
    end else if (cfg_we_i) begin
      case (sfr_reg_e'(cfg_idx_i))
        REG_PAT_LEN:   pat_len_q   <= cfg_data_i[3:0];
        REG_PAT_BYTES: pat_bytes_q <= cfg_data_i;
        REG_REP_LEN:   rep_len_q   <= cfg_data_i[3:0];
        REG_REP_BYTES: rep_bytes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign plen = (pat_len_q > 4'(HoldDepth)) ? 4'(HoldDepth) : pat_len_q;
  assign rlen = (rep_len_q > 4'(RepDepth))  ? 4'(RepDepth)  : rep_len_q;
  assign cnt4 = 4'(cnt_q);

  for (genvar g = 0; g < HoldDepth; g++) begin : g_cell
    sfr_cell_ctl_t ctl;
    logic [7:0]    next_byte;

    assign ctl.shift = pop;
    assign ctl.load  = push && (cnt_q == CntW'(g));

    if (g + 1 < HoldDepth) begin : g_mid
      assign next_byte = held[g + 1];
    end else begin : g_end
      assign next_byte = 8'h00;
    end

    sfr_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .next_i  (next_byte),
      .new_i   (b_q),
      .pat_i   (pat_bytes_q[8*g +: 8]),
      .byte_o  (held[g]),
      .match_o (match[g])
    );
  end

  always_comb begin
    prefix = 1'b1;
    for (int i = 0; i < HoldDepth; i++) begin
      if ((4'(i) < cnt4) && !match[i]) begin
        prefix = 1'b0;
      end
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_v_q || m_axis_tready;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ridx_d    = ridx_q;
    tail_d    = tail_q;
    pop       = 1'b0;
    push      = 1'b0;
    emit      = 1'b0;
    fin       = 1'b0;
    emit_byte = held[0];
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((s_axis_tdata == LINE_END) || (plen == 4'd0)) begin
            tail_d  = 1'b1;
            state_d = S_FLUSH;
          end else begin
            tail_d  = 1'b0;
            state_d = S_TRIM;
          end
        end
      end
      S_TRIM: begin
        if (out_free) begin
          if (cnt4 >= plen) begin
            pop   = 1'b1;
            emit  = 1'b1;
            cnt_d = cnt_q - 1'b1;
          end else begin
            push    = 1'b1;
            cnt_d   = cnt_q + 1'b1;
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (out_free) begin
          if ((cnt4 == plen) && prefix) begin
            cnt_d  = '0;
            ridx_d = 3'd0;
            if (rlen != 4'd0) begin
              state_d = S_REPL;
            end else begin
              state_d = eos_q ? S_FLUSH : S_DONE;
            end
          end else if ((cnt_q != '0) && !prefix) begin
            pop   = 1'b1;
            emit  = 1'b1;
            cnt_d = cnt_q - 1'b1;
          end else begin
            state_d = eos_q ? S_FLUSH : S_DONE;
          end
        end
      end
      S_REPL: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = rep_bytes_q[{ridx_q, 3'b000} +: 8];
          ridx_d    = ridx_q + 3'd1;
          if ((4'(ridx_q) + 4'd1) == rlen) begin
            state_d = eos_q ? S_FLUSH : S_DONE;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          if (cnt_q != '0) begin
            pop   = 1'b1;
            emit  = 1'b1;
            cnt_d = cnt_q - 1'b1;
          end else if (tail_q) begin
            emit      = 1'b1;
            emit_byte = b_q;
            state_d   = S_DONE;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          fin     = pend_v_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign load_out = pend_v_q && (emit || fin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ridx_q   <= 3'd0;
      tail_q   <= 1'b0;
      eos_q    <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ridx_q  <= ridx_d;
      tail_q  <= tail_d;
      if (accept) begin
        eos_q <= s_axis_tlast;
      end
      if (emit) begin
        pend_v_q <= 1'b1;
      end else if (fin) begin
        pend_v_q <= 1'b0;
      end
      if (load_out) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_q <= s_axis_tdata;
    end
    if (emit) begin
      pend_byte_q <= emit_byte;
    end
    if (load_out) begin
      out_byte_q <= pend_byte_q;
      out_last_q <= fin;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

  `SFR_ASSERT(a_accept_clean, clk_i, rst_ni, accept |-> !pend_v_q,
    "request accepted while a result byte is still pending")
  `SFR_ASSERT(a_last_sent, clk_i, rst_ni,
    (state_q == S_DONE && pend_v_q && out_free) |=> (m_axis_tvalid && m_axis_tlast),
    "final result byte of a request not marked last")
  `SFR_ASSERT_NEVER(a_cnt_cap, clk_i, rst_ni, cnt4 > 4'(HoldDepth),
    "hold count exceeds the hold buffer depth")
  `SFR_ASSERT(a_repl_empty, clk_i, rst_ni, (state_q == S_REPL) |-> (cnt_q == '0),
    "hold buffer not empty while sending the replacement")

endmodule

`default_nettype wire

// ===== rtl/sfr_cell.sv =====
// One hold-buffer cell: stores a byte, shifts toward the head, compares to its pattern byte.
`default_nettype none

module sfr_cell import sfr_pkg::*; (
  input  logic          clk_i,
  input  sfr_cell_ctl_t ctl_i,
  input  logic [7:0]    next_i,
  input  logic [7:0]    new_i,
  input  logic [7:0]    pat_i,
  output logic [7:0]    byte_o,
  output logic          match_o
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      byte_q <= new_i;
    end else if (ctl_i.shift) begin
      byte_q <= next_i;
    end
  end

  assign byte_o  = byte_q;
  assign match_o = (byte_q == pat_i);

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the streaming find-and-replace block.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = REG_PAT_LEN;
  logic [63:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // in_byte
  logic        s_axis_tlast = 1'b0; // end_of_stream
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // out_byte
  logic        m_axis_tlast;        // run_last

  stream_find_replace dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Predictor state: register copies and the hold buffer.
  logic [3:0]  pat_len_r = 4'd1;
  logic [63:0] pat_r = '0;
  logic [3:0]  rep_len_r = 4'd0;
  logic [63:0] rep_r = '0;
  logic [7:0]  hold_buf [8];
  int unsigned hold_cnt = 0;
  logic [7:0]  step_bytes [$];
  out_beat_t   expected_bytes [$];

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used = 1;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;
  out_beat_t   want;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, expected_bytes.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!quiet) stall_left = pick_gap();
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_v);
    $display("Mismatch on %s at output byte %0d: got 0x%0h, expected 0x%0h.",
             what, results_checked, got, exp_v);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected output", 32'(m_axis_tdata), 0);
      end else begin
        want = expected_bytes.pop_front();
        if (m_axis_tdata !== want.out_byte)
          report_mismatch("out_byte", 32'(m_axis_tdata), 32'(want.out_byte));
        if (m_axis_tlast !== want.run_last)
          report_mismatch("run_last", 32'(m_axis_tlast), 32'(want.run_last));
      end
      results_checked++;
    end
  end

  function automatic void hold_pop();
    step_bytes.push_back(hold_buf[0]);
    for (int i = 0; i < 7; i++) hold_buf[i] = hold_buf[i + 1];
    hold_cnt--;
  endfunction

  function automatic bit hold_is_prefix();
    for (int i = 0; i < hold_cnt; i++)
      if (hold_buf[i] !== pat_r[8 * i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // Works out the rewritten bytes caused by one accepted input byte.
  function automatic void rewrite_byte(input logic [7:0] b, input logic eos);
    int unsigned plen;
    int unsigned rlen;
    out_beat_t   beat;
    plen = (pat_len_r > 8) ? 8 : pat_len_r;
    rlen = (rep_len_r > 8) ? 8 : rep_len_r;
    step_bytes.delete();
    if (b == LINE_END || plen == 0) begin
      while (hold_cnt > 0) hold_pop();
      step_bytes.push_back(b);
    end else begin
      while (hold_cnt >= plen) hold_pop();
      hold_buf[hold_cnt] = b;
      hold_cnt++;
      if (hold_cnt == plen && hold_is_prefix()) begin
        for (int i = 0; i < rlen; i++) step_bytes.push_back(rep_r[8 * i +: 8]);
        hold_cnt = 0;
      end else begin
        while (hold_cnt > 0 && !hold_is_prefix()) hold_pop();
      end
      if (eos) begin
        while (hold_cnt > 0) hold_pop();
      end
    end
    foreach (step_bytes[i]) begin
      beat.out_byte = step_bytes[i];
      beat.run_last = (i == step_bytes.size() - 1);
      expected_bytes.push_back(beat);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int unsigned gap;
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    rewrite_byte(b, eos);
    items_sent++;
  endtask

  task automatic send_text(input string s, input bit eos_on_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], eos_on_last && (i == s.len() - 1));
  endtask

  // Stops requests, waits for every expected byte, then lets the block settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input sfr_reg_e idx, input logic [63:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [3:0] plen, input logic [63:0] pbytes,
                           input logic [3:0] rlen, input logic [63:0] rbytes);
    logic [63:0] noise;
    drain_results();
    noise = {$urandom, $urandom};
    write_reg(REG_PAT_LEN, {noise[63:4], plen});
    write_reg(REG_PAT_BYTES, pbytes);
    noise = {$urandom, $urandom};
    write_reg(REG_REP_LEN, {noise[63:4], rlen});
    write_reg(REG_REP_BYTES, rbytes);
    cfg_we_i <= 1'b0;
    pat_len_r = plen;
    pat_r     = pbytes;
    rep_len_r = rlen;
    rep_r     = rbytes;
    settings_used++;
  endtask

  // The reset pattern is a single zero byte with an empty replacement.
  task automatic test_reset_values();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(LINE_END, 1'b1);
  endtask

  task automatic test_matching_and_flushes();
    configure(4'd3, 64'h0000_0000_0063_6261, 4'd8, 64'h3736_3534_3332_3130);
    send_text("aababcab\n", 1'b0);
    send_text("ab", 1'b1);
    send_text("ab", 1'b0);
    // The held bytes outlive a switch to a shorter pattern.
    configure(4'd1, 64'h0000_0000_0000_0078, 4'd2, 64'h0000_0000_0000_5958);
    send_text("qx", 1'b0);
  endtask

  task automatic test_disabled_and_saturation();
    configure(4'd2, 64'h0000_0000_0000_7978, 4'd1, 64'h0000_0000_0000_002A);
    send_text("x", 1'b0);
    configure(4'd0, 64'h0000_0000_0000_7978, 4'd1, 64'h0000_0000_0000_002A);
    send_text("zx", 1'b0);
    configure(4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'h0123_4567_89AB_CDEF);
    for (int i = 0; i < 7; i++) send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_random_streams();
    logic [7:0]  sym [2];
    logic [63:0] pbytes;
    logic [3:0]  plen;
    int unsigned span;
    int unsigned count;
    int unsigned r;
    for (int ph = 0; ph < 6; ph++) begin
      r = $urandom_range(0, 9);
      if (r == 0) plen = 4'd0;
      else if (r == 1) plen = 4'($urandom_range(9, 15));
      else plen = 4'($urandom_range(1, 8));
      sym[0] = 8'($urandom_range(0, 255));
      sym[1] = 8'($urandom_range(0, 255));
      for (int i = 0; i < 8; i++)
        pbytes[8 * i +: 8] = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                         : sym[$urandom_range(0, 1)];
      configure(plen, pbytes, 4'($urandom_range(0, 15)), {$urandom, $urandom});
      quiet = ($urandom_range(0, 3) == 0);
      span = (plen == 0) ? 1 : ((plen > 8) ? 8 : plen);
      count = 0;
      while (count < 28) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          for (int i = 0; i < $urandom_range(1, span); i++) begin
            send_byte(pbytes[8 * i +: 8], $urandom_range(0, 24) == 0);
            count++;
          end
        end else if (r < 70) begin
          send_byte(sym[$urandom_range(0, 1)], $urandom_range(0, 24) == 0);
          count++;
        end else if (r < 80) begin
          send_byte(LINE_END, $urandom_range(0, 3) == 0);
          count++;
        end else begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 24) == 0);
          count++;
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_values();
    test_matching_and_flushes();
    test_disabled_and_saturation();
    test_random_streams();
    drain_results();
    $display("Sent %0d input bytes under %0d register settings; checked %0d output bytes.",
             items_sent, settings_used, results_checked);
    $display("%s %s", "Covered deletion, replacement, line and stream-end flushes,",
             "disabled matching, and saturated lengths.");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/sfr_pkg.sv
rtl/sfr_cell.sv
rtl/stream_find_replace.sv
dv/testbench.sv
